FILE: hw/rtl/tpms_pkg.sv
package tpms_pkg;

	// Event codes
	localparam logic [2:0] CMD_START    = 3'd0;
	localparam logic [2:0] CMD_TX_END   = 3'd1;
	localparam logic [2:0] CMD_RX_START = 3'd2;
	localparam logic [2:0] CMD_RX_END   = 3'd3;
	localparam logic [2:0] CMD_TICK     = 3'd4;

	// Result actions
	localparam logic [2:0] ACT_NONE          = 3'd0;
	localparam logic [2:0] ACT_SEND          = 3'd1;
	localparam logic [2:0] ACT_DELIVER       = 3'd2;
	localparam logic [2:0] ACT_DROP_ERR      = 3'd3;
	localparam logic [2:0] ACT_DROP_TYPE     = 3'd4;
	localparam logic [2:0] ACT_DROP_FOREIGN  = 3'd5;
	localparam logic [2:0] ACT_DROP_NOLISTEN = 3'd6;

	// Modes
	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_LISTEN_ON  = 3'd1;
	localparam logic [2:0] MODE_LISTEN_OFF = 3'd2;
	localparam logic [2:0] MODE_DATA       = 3'd3;
	localparam logic [2:0] MODE_SENDING    = 3'd4;

	// Causes
	localparam logic [2:0] CAUSE_UNSET   = 3'd0;
	localparam logic [2:0] CAUSE_SENT    = 3'd1;
	localparam logic [2:0] CAUSE_RXSTART = 3'd2;
	localparam logic [2:0] CAUSE_ERROR   = 3'd3;
	localparam logic [2:0] CAUSE_DATA    = 3'd4;
	localparam logic [2:0] CAUSE_FOREIGN = 3'd5;

	// Register indexes
	localparam logic [1:0] CFG_OWN_ADDR     = 2'd0;
	localparam logic [1:0] CFG_BCAST_ADDR   = 2'd1;
	localparam logic [1:0] CFG_LISTEN_TICKS = 2'd2;
	localparam logic [1:0] CFG_TRIG_SIZE    = 2'd3;

	localparam logic [7:0]  RST_OWN_ADDR     = 8'd0;
	localparam logic [7:0]  RST_BCAST_ADDR   = 8'd255;
	localparam logic [15:0] RST_LISTEN_TICKS = 16'd1000;
	localparam logic [15:0] RST_TRIG_SIZE    = 16'd0;

	typedef struct packed {
		logic [2:0] command;
		logic       frame_error;
		logic [7:0] frame_dest;
		logic       frame_is_trigger;
	} evt_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] tx_length;
		logic [2:0]  mode;
		logic [2:0]  last_cause;
		logic        listening;
		logic [31:0] triggers_sent;
		logic [31:0] data_received;
		logic [31:0] errors_received;
	} res_t;

	typedef struct packed {
		logic [7:0]  own_address;
		logic [7:0]  broadcast_address;
		logic [15:0] listen_ticks;
		logic [15:0] trig_bytes;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [2:0]  cause;
		logic        listen;
		logic [15:0] win_remaining;
		logic        win_running;
		logic [31:0] trig_cnt;
		logic [31:0] data_cnt;
		logic [31:0] err_cnt;
	} mac_state_t;

endpackage

FILE: hw/rtl/tpms_cfg.sv
module tpms_cfg
	import tpms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address       <= RST_OWN_ADDR;
			cfg_q.broadcast_address <= RST_BCAST_ADDR;
			cfg_q.listen_ticks      <= RST_LISTEN_TICKS;
			cfg_q.trig_bytes        <= RST_TRIG_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_ADDR:     cfg_q.own_address       <= cfg_wdata[7:0];
				CFG_BCAST_ADDR:   cfg_q.broadcast_address <= cfg_wdata[7:0];
				CFG_LISTEN_TICKS: cfg_q.listen_ticks      <= cfg_wdata;
				CFG_TRIG_SIZE:    cfg_q.trig_bytes        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/tpms_core.sv
module tpms_core
	import tpms_pkg::*;
(
	input  cfg_t       cfg,
	input  mac_state_t st,
	input  evt_t       evt,
	output mac_state_t st_nxt,
	output res_t       res
);

	logic [2:0] action;
	logic       addr_hit;

	assign addr_hit = (evt.frame_dest == cfg.own_address) ||
	                  (evt.frame_dest == cfg.broadcast_address);

	always_comb begin
		st_nxt = st;
		action = ACT_NONE;
		case (evt.command)
			CMD_START: begin
				st_nxt.win_running   = 1'b0;
				st_nxt.win_remaining = '0;
				st_nxt.mode          = MODE_SENDING;
				if (!st.listen) begin
					st_nxt.trig_cnt = st.trig_cnt + 32'd1;
					action          = ACT_SEND;
				end
			end
			CMD_TX_END: begin
				st_nxt.cause         = CAUSE_SENT;
				st_nxt.mode          = MODE_LISTEN_ON;
				st_nxt.win_remaining = cfg.listen_ticks;
				st_nxt.win_running   = 1'b1;
				st_nxt.listen        = 1'b1;
			end
			CMD_RX_START: begin
				if (st.listen)
					st_nxt.cause = CAUSE_RXSTART;
			end
			CMD_RX_END: begin
				if (!st.listen) begin
					action = ACT_DROP_NOLISTEN;
				end else if (evt.frame_error) begin
					st_nxt.err_cnt = st.err_cnt + 32'd1;
					st_nxt.cause   = CAUSE_ERROR;
					action         = ACT_DROP_ERR;
				end else if (addr_hit) begin
					if (!evt.frame_is_trigger) begin
						st_nxt.cause    = CAUSE_DATA;
						st_nxt.mode     = MODE_DATA;
						st_nxt.data_cnt = st.data_cnt + 32'd1;
						action          = ACT_DELIVER;
					end else begin
						action = ACT_DROP_TYPE;
					end
				end else begin
					st_nxt.cause = CAUSE_FOREIGN;
					action       = ACT_DROP_FOREIGN;
				end
			end
			CMD_TICK: begin
				if (st.win_running) begin
					if (st.win_remaining <= 16'd1) begin
						st_nxt.win_running   = 1'b0;
						st_nxt.win_remaining = '0;
						// timeout: stop listening and poll again, listen is now clear
						if (st.mode != MODE_SENDING) begin
							st_nxt.listen   = 1'b0;
							st_nxt.mode     = MODE_SENDING;
							st_nxt.trig_cnt = st.trig_cnt + 32'd1;
							action          = ACT_SEND;
						end
					end else begin
						st_nxt.win_remaining = st.win_remaining - 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.action          = action;
		res.tx_length       = (action == ACT_SEND) ? cfg.trig_bytes : 16'd0;
		res.mode            = st_nxt.mode;
		res.last_cause      = st_nxt.cause;
		res.listening       = st_nxt.listen;
		res.triggers_sent   = st_nxt.trig_cnt;
		res.data_received   = st_nxt.data_cnt;
		res.errors_received = st_nxt.err_cnt;
	end

endmodule

FILE: hw/rtl/trigger_polling_mac_sink_unit.sv
// An accepted word sits in the input register until the result register is free or
// being drained; its result is then loaded there and the MAC state updates with it.
// Throughput: one word per cycle unless the receiver stalls the result register.
// Reset (arst_n low, asynchronous): MAC state, counters and config go to their
// reset values, both pipeline valids clear.
module trigger_polling_mac_sink_unit
	import tpms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_ready,
	input  evt_t        evt,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg;
	mac_state_t st_q;
	mac_state_t st_nxt;
	res_t       res_nxt;

	// input register
	logic valid_s1;
	evt_t evt_s1;

	// result register
	logic res_valid_q;
	res_t res_q;

	logic advance;

	tpms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tpms_core u_core (
		.cfg    (cfg),
		.st     (st_q),
		.evt    (evt_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// Advance the staged word when the result register is free or being drained.
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	// Take a new word whenever the input register empties at this edge.
	assign evt_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid)
			evt_s1 <= evt;
	end

	// Commit the MAC state only together with the result it produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode          <= MODE_IDLE;
			st_q.cause         <= CAUSE_UNSET;
			st_q.listen        <= 1'b0;
			st_q.win_remaining <= '0;
			st_q.win_running   <= 1'b0;
			st_q.trig_cnt      <= '0;
			st_q.data_cnt      <= '0;
			st_q.err_cnt       <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	// A pending result always mirrors the committed state.
	a_res_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.triggers_sent == st_q.trig_cnt) &&
		(res.mode == st_q.mode) && (res.listening == st_q.listen))
		else $error("result does not match committed state");

	// Length is only reported for trigger requests.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.action != ACT_SEND) |-> (res.tx_length == 16'd0))
		else $error("tx_length set without trigger request");

	// A delivered frame implies the window is open.
	a_deliver_listen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.action == ACT_DELIVER) |-> res.listening)
		else $error("delivery while not listening");

	// An empty input register never blocks the input.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> evt_ready)
		else $error("input stalled while empty");
`endif

endmodule

FILE: test/tb_trigger_polling_mac_sink_unit.sv
`timescale 1ns / 1ps

module tb_trigger_polling_mac_sink_unit;
	import tpms_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_ready;
	evt_t        evt;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// Shadow copy of the sink: its registers and its MAC state
	cfg_t       sink_cfg;
	mac_state_t sink_st;

	// Results still owed by the block, oldest first
	res_t pending_res[$];

	int fault_cnt = 0;
	int sent_cnt  = 0;
	int hold_left = 0;   // receiver holds ready low while this is nonzero
	bit calm      = 1'b0; // no idling on either side while set

	trigger_polling_mac_sink_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	//------------------------------------------------------------------
	// Prediction of the sink
	//------------------------------------------------------------------

	// Cancel the window timer and request a trigger unless still listening.
	task automatic cancel_and_trigger(inout logic [2:0] act);
		sink_st.win_running   = 1'b0;
		sink_st.win_remaining = '0;
		sink_st.mode          = MODE_SENDING;
		if (!sink_st.listen) begin
			sink_st.trig_cnt = sink_st.trig_cnt + 32'd1;
			act = ACT_SEND;
		end
	endtask

	// Apply one event to the shadow state; return the word the block must emit.
	task automatic sink_decide(input evt_t w, output res_t r);
		logic [2:0] act;
		act = ACT_NONE;
		case (w.command)
			CMD_START: begin
				cancel_and_trigger(act);
			end
			CMD_TX_END: begin
				// trigger went out: open the receive window
				sink_st.cause         = CAUSE_SENT;
				sink_st.mode          = MODE_LISTEN_ON;
				sink_st.win_remaining = sink_cfg.listen_ticks;
				sink_st.win_running   = 1'b1;
				sink_st.listen        = 1'b1;
			end
			CMD_RX_START: begin
				if (sink_st.listen)
					sink_st.cause = CAUSE_RXSTART;
			end
			CMD_RX_END: begin
				if (!sink_st.listen) begin
					act = ACT_DROP_NOLISTEN;
				end else if (w.frame_error) begin
					sink_st.err_cnt = sink_st.err_cnt + 32'd1;
					sink_st.cause   = CAUSE_ERROR;
					act = ACT_DROP_ERR;
				end else if (w.frame_dest == sink_cfg.own_address ||
					     w.frame_dest == sink_cfg.broadcast_address) begin
					if (!w.frame_is_trigger) begin
						sink_st.cause    = CAUSE_DATA;
						sink_st.mode     = MODE_DATA;
						sink_st.data_cnt = sink_st.data_cnt + 32'd1;
						act = ACT_DELIVER;
					end else begin
						// trigger frames heard here are dropped, cause kept
						act = ACT_DROP_TYPE;
					end
				end else begin
					sink_st.cause = CAUSE_FOREIGN;
					act = ACT_DROP_FOREIGN;
				end
			end
			CMD_TICK: begin
				if (sink_st.win_running) begin
					if (sink_st.win_remaining <= 16'd1) begin
						sink_st.win_running   = 1'b0;
						sink_st.win_remaining = '0;
						// timeout while a trigger is pending only stops the timer
						if (sink_st.mode != MODE_SENDING) begin
							sink_st.mode   = MODE_LISTEN_OFF;
							sink_st.listen = 1'b0;
							cancel_and_trigger(act);
						end
					end else begin
						sink_st.win_remaining = sink_st.win_remaining - 16'd1;
					end
				end
			end
			default: ;
		endcase
		r.action          = act;
		r.tx_length       = (act == ACT_SEND) ? sink_cfg.trig_bytes : 16'd0;
		r.mode            = sink_st.mode;
		r.last_cause      = sink_st.cause;
		r.listening       = sink_st.listen;
		r.triggers_sent   = sink_st.trig_cnt;
		r.data_received   = sink_st.data_cnt;
		r.errors_received = sink_st.err_cnt;
	endtask

	function automatic string fmt_res(res_t r);
		return $sformatf({"act=%0d len=%0d mode=%0d cause=%0d listen=%0b",
			" trig=%0d data=%0d err=%0d"},
			r.action, r.tx_length, r.mode, r.last_cause, r.listening,
			r.triggers_sent, r.data_received, r.errors_received);
	endfunction

	task automatic note_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%s", msg);
	endtask

	//------------------------------------------------------------------
	// Monitor: predict on every accepted event word, then check every
	// accepted result word against the oldest prediction. Both sides are
	// sampled at the edge, so values are the ones the block saw.
	//------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		res_t want;
		res_t oldest;
		if (arst_n) begin
			if (evt_valid && evt_ready) begin
				sink_decide(evt, want);
				pending_res.push_back(want);
			end
			if (res_valid && res_ready) begin
				if (pending_res.size() == 0) begin
					note_fault($sformatf("unexpected result at %0t: %s",
						$realtime, fmt_res(res)));
				end else begin
					oldest = pending_res.pop_front();
					if (res !== oldest)
						note_fault($sformatf("mismatch at %0t\n  exp %s\n  got %s",
							$realtime, fmt_res(oldest), fmt_res(res)));
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Receiver: random stalls, a forced hold-off when asked, none when calm
	//------------------------------------------------------------------
	initial begin : receiver
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(99) >= 38);
			end
		end
	end

	//------------------------------------------------------------------
	// Shared stimulus helpers
	//------------------------------------------------------------------

	function automatic evt_t mk_evt(logic [2:0] cmd, logic ferr, logic [7:0] dest, logic ftrig);
		evt_t e;
		e.command          = cmd;
		e.frame_error      = ferr;
		e.frame_dest       = dest;
		e.frame_is_trigger = ftrig;
		return e;
	endfunction

	// Given command, random frame fields (ignored unless rx end)
	function automatic evt_t rand_evt(logic [2:0] cmd);
		return mk_evt(cmd, 1'($urandom_range(1)), 8'($urandom_range(255)),
			1'($urandom_range(1)));
	endfunction

	// Rx end biased toward frames that hit this node or broadcast
	function automatic evt_t rand_frame();
		evt_t e;
		int   roll;
		e    = rand_evt(CMD_RX_END);
		roll = $urandom_range(99);
		if (roll < 40)
			e.frame_dest = sink_cfg.own_address;
		else if (roll < 65)
			e.frame_dest = sink_cfg.broadcast_address;
		e.frame_error      = ($urandom_range(99) < 20);
		e.frame_is_trigger = ($urandom_range(99) < 20);
		return e;
	endfunction

	// Offer one word; drop valid for a random gap first. Valid is only
	// lowered when a gap follows, so it never drops and rises in one step.
	task automatic send_word(input evt_t w);
		if (!calm && $urandom_range(99) < 38) begin
			evt_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		evt_valid <= 1'b1;
		evt       <= w;
		do @(posedge clk); while (!evt_ready);
		sent_cnt++;
	endtask

	// Stop offering and wait until every predicted word has come back
	task automatic drain_results();
		evt_valid <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_OWN_ADDR:     sink_cfg.own_address       = data[7:0];
			CFG_BCAST_ADDR:   sink_cfg.broadcast_address = data[7:0];
			CFG_LISTEN_TICKS: sink_cfg.listen_ticks      = data;
			CFG_TRIG_SIZE:    sink_cfg.trig_bytes        = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] own, input logic [7:0] bcast,
				  input logic [15:0] ticks, input logic [15:0] size);
		write_reg(CFG_OWN_ADDR, {8'd0, own});
		write_reg(CFG_BCAST_ADDR, {8'd0, bcast});
		write_reg(CFG_LISTEN_TICKS, ticks);
		write_reg(CFG_TRIG_SIZE, size);
	endtask

	// One polling round: start, then one or more trigger/listen windows
	// with random traffic, ticks and the odd stray event.
	task automatic run_session();
		int rounds;
		int k;
		int roll;
		send_word(rand_evt(CMD_START));
		rounds = $urandom_range(1, 3);
		repeat (rounds) begin
			send_word(rand_evt(CMD_TX_END));
			k = $urandom_range(1, 14);
			repeat (k) begin
				roll = $urandom_range(99);
				if (roll < 20)
					send_word(rand_evt(CMD_RX_START));
				else if (roll < 55)
					send_word(rand_frame());
				else if (roll < 90)
					send_word(rand_evt(CMD_TICK));
				else if (roll < 95)
					send_word(rand_evt(CMD_START));
				else
					send_word(rand_evt(3'($urandom_range(CMD_TICK))));
			end
		end
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	// Events with the receive window closed, under reset configuration
	task automatic test_idle_events();
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_RX_START, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_TICK, 1'b1, 8'd255, 1'b1));
		send_word(mk_evt(CMD_RX_END, 1'b1, 8'd255, 1'b1));
		send_word(mk_evt(CMD_START, 1'b0, 8'd0, 1'b0));
		drain_results();
	endtask

	// Every drop reason, start while listening, and a listen window timeout
	task automatic test_listen_window();
		set_config(8'd254, 8'd0, 16'd2, 16'hFFFF);
		send_word(mk_evt(CMD_START, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_TX_END, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_RX_START, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd254, 1'b0));  // own address
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd0, 1'b0));    // broadcast
		send_word(mk_evt(CMD_RX_END, 1'b1, 8'd254, 1'b0));  // corrupted
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd254, 1'b1));  // trigger frame
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd7, 1'b0));    // foreign
		send_word(mk_evt(CMD_RX_END, 1'b1, 8'd255, 1'b1));
		// start while listening: no trigger, window cancelled
		send_word(mk_evt(CMD_START, 1'b1, 8'd255, 1'b1));
		send_word(mk_evt(CMD_TICK, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_TICK, 1'b0, 8'd0, 1'b0));
		// timer already stopped: tick ignored
		send_word(mk_evt(CMD_TICK, 1'b0, 8'd0, 1'b0));
		// reopen, then let the window run out
		send_word(mk_evt(CMD_TX_END, 1'b1, 8'd255, 1'b1));
		send_word(mk_evt(CMD_TICK, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_TICK, 1'b0, 8'd0, 1'b0));
		send_word(mk_evt(CMD_RX_END, 1'b0, 8'd254, 1'b0));
		drain_results();
	endtask

	// Hold the receiver off long enough for the block to fill and stall
	// its input, while the sender keeps offering words.
	task automatic test_backpressure();
		set_config(8'($urandom_range(254)), 8'd255, 16'd5, 16'($urandom_range(65535)));
		hold_left = 300;
		repeat (3) run_session();
		drain_results();
	endtask

	// Several configurations, extremes first, mostly well-formed rounds
	task automatic test_random_traffic();
		int         goal;
		logic [7:0] own_a;
		logic [7:0] bc_a;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_config(8'd254, 8'd0, 16'd1, 16'hFFFF);
				1: set_config(8'd0, 8'd255, 16'hFFFF, 16'd0);
				default: begin
					own_a = 8'($urandom_range(254));
					bc_a  = ($urandom_range(99) < 20) ? own_a : 8'($urandom_range(255));
					set_config(own_a, bc_a, 16'($urandom_range(1, 12)),
						16'($urandom_range(65535)));
				end
			endcase
			// one phase with no idling anywhere
			calm = (p == 3);
			goal = sent_cnt + 180;
			while (sent_cnt < goal) begin
				if ($urandom_range(99) < 10)
					send_word(rand_evt(3'($urandom_range(CMD_TICK))));
				else
					run_session();
			end
			drain_results();
			calm = 1'b0;
		end
	endtask

	//------------------------------------------------------------------
	// Main sequence
	//------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		evt_valid = 1'b0;
		evt       = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_OWN_ADDR;
		cfg_wdata = '0;

		sink_cfg.own_address       = RST_OWN_ADDR;
		sink_cfg.broadcast_address = RST_BCAST_ADDR;
		sink_cfg.listen_ticks      = RST_LISTEN_TICKS;
		sink_cfg.trig_bytes        = RST_TRIG_SIZE;
		sink_st.mode               = MODE_IDLE;
		sink_st.cause              = CAUSE_UNSET;
		sink_st.listen             = 1'b0;
		sink_st.win_remaining      = '0;
		sink_st.win_running        = 1'b0;
		sink_st.trig_cnt           = '0;
		sink_st.data_cnt           = '0;
		sink_st.err_cnt            = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_events();
		test_listen_window();
		test_backpressure();
		test_random_traffic();

		// give any stray word time to show up
		repeat (8) @(posedge clk);
		if (pending_res.size() != 0)
			note_fault($sformatf("%0d results never arrived", pending_res.size()));

		if (fault_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
